// ----- design/xpr_pkg.sv -----
// Shared constants, codes and CRC helper for the packet receiver.
`default_nettype none
package xpr_pkg;

    // line control bytes
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_CAN = 8'h18;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int BLOCK_BYTES_DEF = 128;
    localparam int MAX_RETRIES_DEF = 25;

    // retry budget holds up to MAX_RETRIES + 1 (max 31)
    localparam int RETRY_W = 5;

    typedef enum logic [1:0] {
        REPLY_ACK = 2'd0,
        REPLY_NAK = 2'd1,
        REPLY_CAN = 2'd2
    } reply_t;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_DUP     = 3'd1,
        ST_BAD     = 3'd2,
        ST_END     = 3'd3,
        ST_RCANCEL = 3'd4,
        ST_RETRIES = 3'd5,
        ST_REFUSED = 3'd6
    } status_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/xmodem_packet_receiver_top.sv -----
// XMODEM packet receiver: parses line bytes, checks packets, issues replies.
`default_nettype none
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata[7:0] rx_byte
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata[1:0] reply,
//            |     |                                | [4:2] status, [12:5] packet_number
//  cfg       | in  | cfg_valid / cfg_ready          | cfg_data[0] crc_mode
//
//  One beat per cycle while s_axis_tready is high: each byte is folded into the state
//  in the cycle it is accepted (byte-wide CRC update and packet judge are
//  combinational), and any reply lands in the output register on the same edge.
//  s_axis_tready drops only while a reply sits unclaimed in the output
//  register; it is high again in the cycle m_axis_tready takes it.
//  Reset (aresetn low, synchronous) returns to idle, expected number 1,
//  retry budget MAX_RETRIES, crc_mode 1. No clearing pass; ready right after reset.
//  cfg_ready is always high.
//
module xmodem_packet_receiver_top #(
    parameter int BLOCK_BYTES = xpr_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_RETRIES = xpr_pkg::MAX_RETRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [1:0] reply, [4:2] status,
                                             // [12:5] packet_number, [15:13] zero

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data        // [0] crc_mode
);

    localparam int POS_W = $clog2(BLOCK_BYTES + 1);
    localparam int RW    = xpr_pkg::RETRY_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_DATA,
        PH_TRAIL
    } phase_t;

    // state
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         expected_reg, expected_next;
    logic [7:0]         number_reg, number_next;
    logic [7:0]         compl_reg, compl_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         check_hi_reg, check_hi_next;   // first CRC trailer byte
    logic [RW-1:0]      retry_reg, retry_next;
    logic               saw_can_reg, saw_can_next;
    logic               crc_mode_reg, crc_mode_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    xpr_pkg::reply_t    reply_reg, reply_next;
    xpr_pkg::status_t   status_reg, status_next;
    logic [7:0]         num_out_reg, num_out_next;

    logic               in_beat;
    logic [7:0]         b;

    // judge terms
    logic               do_judge;
    logic               check_ok;
    logic               num_ok, is_new, is_dup;
    logic [RW-1:0]      budget_base, budget_dec;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, num_out_reg, status_reg, reply_reg};

    assign num_ok      = (~compl_reg) == number_reg;
    assign is_new      = number_reg == expected_reg;
    assign is_dup      = number_reg == 8'(expected_reg - 8'd1);
    assign budget_base = is_new ? RW'(MAX_RETRIES + 1) : retry_reg;
    assign budget_dec  = (budget_base != '0) ? RW'(budget_base - RW'(1)) : budget_base;

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        expected_next  = expected_reg;
        number_next    = number_reg;
        compl_next     = compl_reg;
        crc_next       = crc_reg;
        sum_next       = sum_reg;
        check_hi_next  = check_hi_reg;
        retry_next     = retry_reg;
        saw_can_next   = saw_can_reg;
        crc_mode_next  = crc_mode_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        reply_next     = reply_reg;
        status_next    = status_reg;
        num_out_next   = num_out_reg;
        do_judge       = 1'b0;
        check_ok       = 1'b0;

        if (cfg_valid) begin
            crc_mode_next = cfg_data;
        end

        if (in_beat) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (saw_can_reg) begin
                        saw_can_next = 1'b0;
                        if (b == xpr_pkg::B_CAN) begin
                            expected_next  = 8'd1;
                            retry_next     = RW'(MAX_RETRIES);
                            pos_next       = '0;
                            out_valid_next = 1'b1;
                            reply_next     = xpr_pkg::REPLY_ACK;
                            status_next    = xpr_pkg::ST_RCANCEL;
                            num_out_next   = 8'd0;
                        end
                    end else if (b == xpr_pkg::B_SOH) begin
                        phase_next = PH_HEAD;
                        pos_next   = '0;
                        crc_next   = 16'd0;
                        sum_next   = 8'd0;
                        check_hi_next = 8'd0;
                    end else if (b == xpr_pkg::B_EOT || b == xpr_pkg::B_STX) begin
                        expected_next  = 8'd1;
                        retry_next     = RW'(MAX_RETRIES);
                        pos_next       = '0;
                        out_valid_next = 1'b1;
                        num_out_next   = 8'd0;
                        if (b == xpr_pkg::B_EOT) begin
                            reply_next  = xpr_pkg::REPLY_ACK;
                            status_next = xpr_pkg::ST_END;
                        end else begin
                            reply_next  = xpr_pkg::REPLY_CAN;
                            status_next = xpr_pkg::ST_REFUSED;
                        end
                    end else if (b == xpr_pkg::B_CAN) begin
                        saw_can_next = 1'b1;
                    end
                end
                PH_HEAD: begin
                    if (pos_reg == '0) begin
                        number_next = b;
                        pos_next    = POS_W'(1);
                    end else begin
                        compl_next = b;
                        phase_next = PH_DATA;
                        pos_next   = '0;
                    end
                end
                PH_DATA: begin
                    crc_next = xpr_pkg::crc_byte(crc_reg, b);
                    sum_next = 8'(sum_reg + b);
                    if (POS_W'(pos_reg + POS_W'(1)) == POS_W'(BLOCK_BYTES)) begin
                        phase_next = PH_TRAIL;
                        pos_next   = '0;
                    end else begin
                        pos_next = POS_W'(pos_reg + POS_W'(1));
                    end
                end
                PH_TRAIL: begin
                    if (pos_reg == '0) begin
                        if (!crc_mode_reg) begin
                            do_judge = 1'b1;
                            check_ok = b == sum_reg;
                        end else begin
                            check_hi_next = b;
                            pos_next      = POS_W'(1);
                        end
                    end else begin
                        do_judge = 1'b1;
                        check_ok = {check_hi_reg, b} == crc_reg;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_judge) begin
                phase_next     = PH_IDLE;
                pos_next       = '0;
                out_valid_next = 1'b1;
                num_out_next   = number_reg;
                if (!(num_ok && (is_new || is_dup) && check_ok)) begin
                    reply_next  = xpr_pkg::REPLY_NAK;
                    status_next = xpr_pkg::ST_BAD;
                end else if (budget_dec == '0) begin
                    // good repeat drained the budget: cancel and start over
                    expected_next = 8'd1;
                    retry_next    = RW'(MAX_RETRIES);
                    saw_can_next  = 1'b0;
                    reply_next    = xpr_pkg::REPLY_CAN;
                    status_next   = xpr_pkg::ST_RETRIES;
                end else begin
                    retry_next  = budget_dec;
                    reply_next  = xpr_pkg::REPLY_ACK;
                    if (is_new) begin
                        expected_next = 8'(expected_reg + 8'd1);
                        status_next   = xpr_pkg::ST_NEW;
                    end else begin
                        status_next   = xpr_pkg::ST_DUP;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            expected_reg  <= 8'd1;
            number_reg    <= 8'd0;
            compl_reg     <= 8'd0;
            crc_reg       <= 16'd0;
            sum_reg       <= 8'd0;
            check_hi_reg  <= 8'd0;
            retry_reg     <= RW'(MAX_RETRIES);
            saw_can_reg   <= 1'b0;
            crc_mode_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            expected_reg  <= expected_next;
            number_reg    <= number_next;
            compl_reg     <= compl_next;
            crc_reg       <= crc_next;
            sum_reg       <= sum_next;
            check_hi_reg  <= check_hi_next;
            retry_reg     <= retry_next;
            saw_can_reg   <= saw_can_next;
            crc_mode_reg  <= crc_mode_next;
            out_valid_reg <= out_valid_next;
        end
        reply_reg   <= reply_next;
        status_reg  <= status_next;
        num_out_reg <= num_out_next;
    end

endmodule
`default_nettype wire
